### src/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // op codes carried on s_tuser
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic start;     // load a new line, emit its first pixel
        logic advance;   // step accumulators, emit next pixel
        logic load_inc;  // capture increments from the divider
    } cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a beat this cycle
        logic steps_zero;  // incoming line has zero length
        logic div_done;    // divider finishes this cycle
        logic last_pixel;  // next advance emits the final pixel
    } status_t;

endpackage

### src/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// Fixed-point DDA line rasterizer, one pixel beat per start beat or per advance beat during a line.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser carries op (0 = start a line, 1 = advance).
// A start beat carries both endpoints and yields the first pixel; each
// advance beat yields the next pixel, steps + 1 pixels per line, the final
// one flagged on m_tlast. An advance while no line is active is consumed
// and yields nothing; a start beat always restarts.
// Output channel m_*: one registered pixel beat, shown the cycle after the
// beat that caused it.
// Throughput: after a start beat of nonzero length the input stalls while
// the bit-serial divider forms both increments; advance beats then go one
// per cycle while m_tready holds, set by one accumulator add per axis per
// pixel. A zero-length line takes no division.
// When m_tready is low the output register holds its beat and s_tready
// drops until that beat is taken. Reset leaves the block idle with the
// output empty.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int  COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int  FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // start_x, start_y, end_x, end_y
    input  logic [0:0]          s_tuser,   // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // pixel_x, pixel_y
    output logic                m_tlast    // last
);

    dlr_pkg::cmd_t         cmd;
    dlr_pkg::status_t      status;
    logic [COORD_BITS-1:0] pixel_x, pixel_y;

    dlr_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (s_tuser[0]),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    dlr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .start_x   (s_tdata[COORD_BITS-1:0]),
        .start_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x     (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y     (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .out_ready (m_tready),
        .status    (status),
        .out_valid (m_tvalid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (m_tlast)
    );

    assign m_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

### src/dlr_divider.sv
// ----------------------------------------------------------------------------
// dlr_divider
// Two-lane restoring divider: q = a * 2^FRAC_BITS / d for a <= d, one bit
// per cycle. Both lanes share the divisor.
// ----------------------------------------------------------------------------
module dlr_divider #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [COORD_BITS-1:0] a_x,
    input  logic [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-1:0] divisor,
    output logic [FRAC_BITS:0]    q_x,
    output logic [FRAC_BITS:0]    q_y,
    output logic                  done
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [COORD_BITS:0]   rem_x_reg, rem_x_next;
    logic [COORD_BITS:0]   rem_y_reg, rem_y_next;
    logic [FRAC_BITS:0]    q_x_reg, q_x_next;
    logic [FRAC_BITS:0]    q_y_reg, q_y_next;
    logic [COORD_BITS-1:0] div_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;

    logic [COORD_BITS:0]   sh_x, sh_y, dv;
    logic                  ge_x, ge_y, final_step;

    assign dv         = {1'b0, div_reg};
    // first step takes the integer bit without shifting
    assign sh_x       = (cnt_reg == '0) ? rem_x_reg : {rem_x_reg[COORD_BITS-1:0], 1'b0};
    assign sh_y       = (cnt_reg == '0) ? rem_y_reg : {rem_y_reg[COORD_BITS-1:0], 1'b0};
    assign ge_x       = (sh_x >= dv);
    assign ge_y       = (sh_y >= dv);
    assign final_step = run_reg && (cnt_reg == CNT_W'(FRAC_BITS));

    always_comb
    begin
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        q_x_next   = q_x_reg;
        q_y_next   = q_y_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        if (load)
        begin
            rem_x_next = {1'b0, a_x};
            rem_y_next = {1'b0, a_y};
            q_x_next   = '0;
            q_y_next   = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            rem_x_next = ge_x ? (sh_x - dv) : sh_x;
            rem_y_next = ge_y ? (sh_y - dv) : sh_y;
            q_x_next   = {q_x_reg[FRAC_BITS-1:0], ge_x};
            q_y_next   = {q_y_reg[FRAC_BITS-1:0], ge_y};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (final_step)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        q_x_reg   <= q_x_next;
        q_y_reg   <= q_y_next;
        if (load)
        begin
            div_reg <= divisor;
        end
    end

    // quotient includes the bit decided in the final step
    assign q_x  = {q_x_reg[FRAC_BITS-1:0], ge_x};
    assign q_y  = {q_y_reg[FRAC_BITS-1:0], ge_y};
    assign done = final_step;

endmodule

### src/dlr_controller.sv
// ----------------------------------------------------------------------------
// dlr_controller
// Line sequencer: idle, increment division, pixel run.
// ----------------------------------------------------------------------------
module dlr_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             op,
    input  dlr_pkg::status_t status,
    output logic             in_ready,
    output dlr_pkg::cmd_t    cmd
);

    dlr_pkg::state_t state_reg, state_next;
    logic            accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlr_pkg::ST_IDLE,
            dlr_pkg::ST_RUN:
            begin
                if (accept && (op == dlr_pkg::OP_START))
                begin
                    state_next = status.steps_zero ? dlr_pkg::ST_IDLE : dlr_pkg::ST_DIVIDE;
                end
                else if (accept && (state_reg == dlr_pkg::ST_RUN) && status.last_pixel)
                begin
                    state_next = dlr_pkg::ST_IDLE;
                end
            end
            dlr_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = dlr_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = dlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.start    = 1'b0;
        cmd.advance  = 1'b0;
        cmd.load_inc = 1'b0;
        unique case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                in_ready  = status.out_free;
                cmd.start = in_valid && status.out_free && (op == dlr_pkg::OP_START);
            end
            dlr_pkg::ST_RUN:
            begin
                in_ready    = status.out_free;
                cmd.start   = in_valid && status.out_free && (op == dlr_pkg::OP_START);
                cmd.advance = in_valid && status.out_free && (op == dlr_pkg::OP_ADVANCE);
            end
            dlr_pkg::ST_DIVIDE:
            begin
                cmd.load_inc = status.div_done;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/dlr_datapath.sv
// ----------------------------------------------------------------------------
// dlr_datapath
// Endpoint deltas, increment divider, position accumulators, output register.
// ----------------------------------------------------------------------------
module dlr_datapath #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dlr_pkg::cmd_t         cmd,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic                  out_ready,
    output dlr_pkg::status_t      status,
    output logic                  out_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);

    localparam int ACC_W = COORD_BITS + 1 + FRAC_BITS;
    localparam int INC_W = FRAC_BITS + 2;

    logic [COORD_BITS:0]   dx, dy, ndx, ndy;
    logic [COORD_BITS-1:0] adx, ady, steps;
    logic [FRAC_BITS:0]    q_x, q_y;
    logic                  div_done;

    logic [ACC_W-1:0]      acc_x_reg, acc_y_reg, acc_x_next, acc_y_next;
    logic [ACC_W-1:0]      rnd_x, rnd_y, half;
    logic [INC_W-1:0]      inc_x_reg, inc_y_reg, pq_x, pq_y;
    logic [COORD_BITS-1:0] left_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic                  valid_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  last_reg;

    assign dx  = {1'b0, end_x} - {1'b0, start_x};
    assign dy  = {1'b0, end_y} - {1'b0, start_y};
    assign ndx = -dx;
    assign ndy = -dy;
    assign adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    assign steps = (adx > ady) ? adx : ady;

    dlr_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (cmd.start && (steps != '0)),
        .a_x     (adx),
        .a_y     (ady),
        .divisor (steps),
        .q_x     (q_x),
        .q_y     (q_y),
        .done    (div_done)
    );

    // truncation toward zero: divide magnitudes, then restore the sign
    assign pq_x = {1'b0, q_x};
    assign pq_y = {1'b0, q_y};

    assign acc_x_next = acc_x_reg + {{(ACC_W-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
    assign acc_y_next = acc_y_reg + {{(ACC_W-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};

    // round half up
    assign half  = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    assign rnd_x = acc_x_next + half;
    assign rnd_y = acc_y_next + half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            if (cmd.start || cmd.advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.start)
            begin
                left_reg <= steps;
            end
            else if (cmd.advance)
            begin
                left_reg <= left_reg - COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_x_reg <= {1'b0, start_x, {FRAC_BITS{1'b0}}};
            acc_y_reg <= {1'b0, start_y, {FRAC_BITS{1'b0}}};
            neg_x_reg <= dx[COORD_BITS];
            neg_y_reg <= dy[COORD_BITS];
            px_reg    <= start_x;
            py_reg    <= start_y;
            last_reg  <= (steps == '0);
        end
        else if (cmd.advance)
        begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            px_reg    <= rnd_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            py_reg    <= rnd_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            last_reg  <= (left_reg == COORD_BITS'(1));
        end
        if (cmd.load_inc)
        begin
            inc_x_reg <= neg_x_reg ? -pq_x : pq_x;
            inc_y_reg <= neg_y_reg ? -pq_y : pq_y;
        end
    end

    assign status.out_free   = !valid_reg || out_ready;
    assign status.steps_zero = (steps == '0);
    assign status.div_done   = div_done;
    assign status.last_pixel = (left_reg == COORD_BITS'(1));

    assign out_valid = valid_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign last      = last_reg;

endmodule
